// File: sv/cbm_pkg.sv
// Cartridge bank mapper package: command and target codes, register
// addresses, bank-state and result structs. No dependencies.
package cbm_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_PPU   = 2'd2;

  localparam logic [2:0] TGT_NONE     = 3'd0;
  localparam logic [2:0] TGT_PROGRAM  = 3'd1;
  localparam logic [2:0] TGT_WORK     = 3'd2;
  localparam logic [2:0] TGT_CHAR     = 3'd3;
  localparam logic [2:0] TGT_REGISTER = 3'd4;

  localparam logic [15:0] CHR_REG_LO = 16'h7EF0;
  localparam logic [15:0] CHR_REG_HI = 16'h7EF5;
  localparam logic [15:0] CTRL_REG   = 16'h7EF6;
  localparam logic [15:0] PRG_REG_LO = 16'h7EFA;
  localparam logic [15:0] PRG_REG_HI = 16'h7EFC;
  localparam logic [15:0] WRAM_LO    = 16'h6000;
  localparam logic [15:0] WRAM_HI    = 16'h7FFF;
  localparam logic [15:0] PPU_END    = 16'h2000;

  localparam logic [5:0] FIXED_BANK = 6'd63;
  localparam logic [1:0] LAST_WIN   = 2'd3;

  typedef struct packed {
    logic [1:0]      ctrl;
    logic [5:0][7:0] chr;
    logic [2:0][5:0] prg;
  } bank_state_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] addr;
    logic        mirroring;
  } result_t;

endpackage

// File: sv/cbm_decode.sv
// Single-pass decode of one bus access: register loads, work memory,
// program and character window translation. Depends on cbm_pkg.
module cbm_decode (
  input  logic [1:0]          command,
  input  logic [15:0]         bus_address,
  input  logic [7:0]          write_data,
  input  cbm_pkg::bank_state_t cur,
  output cbm_pkg::bank_state_t nxt,
  output cbm_pkg::result_t    res
);

  logic [1:0]  prg_idx;
  logic [1:0]  win;
  logic [5:0]  prg_bank;
  logic [2:0]  chr_1k_idx;
  logic [18:0] prg_addr;
  logic [18:0] chr_addr;
  logic [18:0] wram_addr;

  // register block offset: 0x7EFA..0x7EFC -> 0..2 from the low two bits
  assign prg_idx    = 2'(bus_address[1:0] - 2'd2);
  assign win        = bus_address[14:13];
  assign prg_bank   = (win == cbm_pkg::LAST_WIN) ? cbm_pkg::FIXED_BANK : cur.prg[win];
  assign prg_addr   = {prg_bank, bus_address[12:0]};
  assign wram_addr  = {6'd0, bus_address[12:0]};
  assign chr_1k_idx = 3'(3'd2 + {1'b0, bus_address[11:10]});

  always_comb begin
    if ((bus_address[12] ^ cur.ctrl[1]) == 1'b0) begin
      chr_addr = {1'b0, cur.chr[{2'd0, bus_address[11]}][7:1], bus_address[10:0]};
    end else begin
      chr_addr = {1'b0, cur.chr[chr_1k_idx], bus_address[9:0]};
    end
  end

  always_comb begin
    nxt        = cur;
    res.target = cbm_pkg::TGT_NONE;
    res.addr   = '0;
    case (command)
      cbm_pkg::CMD_WRITE: begin
        if (bus_address inside {[cbm_pkg::CHR_REG_LO:cbm_pkg::CHR_REG_HI]}) begin
          nxt.chr[bus_address[2:0]] = write_data;
          res.target = cbm_pkg::TGT_REGISTER;
        end else if (bus_address == cbm_pkg::CTRL_REG) begin
          nxt.ctrl = write_data[1:0];
          res.target = cbm_pkg::TGT_REGISTER;
        end else if (bus_address inside {[cbm_pkg::PRG_REG_LO:cbm_pkg::PRG_REG_HI]}) begin
          nxt.prg[prg_idx] = write_data[7:2];
          res.target = cbm_pkg::TGT_REGISTER;
        end else if (bus_address inside {[cbm_pkg::CTRL_REG + 16'd1:
                                          cbm_pkg::PRG_REG_LO - 16'd1]}) begin
          // unused holes in the register block: no effect
          res.target = cbm_pkg::TGT_NONE;
        end else if (bus_address inside {[cbm_pkg::WRAM_LO:cbm_pkg::WRAM_HI]}) begin
          res.target = cbm_pkg::TGT_WORK;
          res.addr   = wram_addr;
        end
      end
      cbm_pkg::CMD_READ: begin
        if (bus_address[15]) begin
          res.target = cbm_pkg::TGT_PROGRAM;
          res.addr   = prg_addr;
        end else if (bus_address >= cbm_pkg::WRAM_LO) begin
          res.target = cbm_pkg::TGT_WORK;
          res.addr   = wram_addr;
        end
      end
      cbm_pkg::CMD_PPU: begin
        if (bus_address < cbm_pkg::PPU_END) begin
          res.target = cbm_pkg::TGT_CHAR;
          res.addr   = chr_addr;
        end
      end
      default: begin
        res.target = cbm_pkg::TGT_NONE;
      end
    endcase
    // mirroring reflects any control update made by this access
    res.mirroring = nxt.ctrl[0];
  end

endmodule

// File: sv/cartridge_bank_mapper_unit.sv
// Cartridge bank mapper top level: request register, decode, bank state
// and result register. Depends on cbm_pkg and cbm_decode.
//
// Usage:
//   Request channel (req_valid / req_stall) carries command, bus_address
//   and write_data. Result channel (rsp_valid / rsp_stall) carries target,
//   mapped_address and mirroring, one result per request, in order.
//   A transfer happens on a rising edge with valid high and stall low.
//   Path: an accepted request goes into the request register and its
//   result into the result register; the decode between them is a
//   single combinational pass.
//   Throughput: one request per cycle, sustained, while the receiver
//   takes results; set by the two-register pipeline, not by any loop.
//   Bank registers are updated as a request passes the decode stage, so
//   later requests see the new banks.
//   Reset (rst, synchronous): pipeline empty, control bits zero,
//   character banks zero, program banks 0, 1, 2.
//   Receiver stall: the result register holds; one more request may sit
//   in the request register, after which req_stall rises.
module cartridge_bank_mapper_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  command,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  target,
  output logic [18:0] mapped_address,
  output logic        mirroring
);

  logic                 s1_valid;
  logic [1:0]           s1_cmd;
  logic [15:0]          s1_addr;
  logic [7:0]           s1_data;
  cbm_pkg::bank_state_t banks;
  cbm_pkg::bank_state_t banks_next;
  cbm_pkg::result_t     res;
  logic                 out_free;
  logic                 s1_move;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign s1_move   = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;

  cbm_decode u_decode (
    .command     (s1_cmd),
    .bus_address (s1_addr),
    .write_data  (s1_data),
    .cur         (banks),
    .nxt         (banks_next),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      banks.ctrl <= 2'd0;
      banks.chr  <= '0;
      banks.prg  <= {6'd2, 6'd1, 6'd0};
    end else begin
      if (!req_stall) begin
        s1_valid <= req_valid;
      end
      if (out_free) begin
        rsp_valid <= s1_valid;
      end
      if (s1_move) begin
        banks <= banks_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_cmd  <= command;
      s1_addr <= bus_address;
      s1_data <= write_data;
    end
    if (s1_move) begin
      target         <= res.target;
      mapped_address <= res.addr;
      mirroring      <= res.mirroring;
    end
  end

  a_reg_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && target == cbm_pkg::TGT_REGISTER |-> mapped_address == 19'd0)
    else $error("register transfer carries a nonzero address");

  a_chr_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && target == cbm_pkg::TGT_CHAR |-> mapped_address[18] == 1'b0)
    else $error("character address beyond 256K");

  a_wram_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && target == cbm_pkg::TGT_WORK |-> mapped_address[18:13] == 6'd0)
    else $error("work memory address beyond 8K");

  a_mirror_ctrl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && $past(s1_move) |-> mirroring == banks.ctrl[0])
    else $error("mirroring out of step with control register");

  // first edge after reset is released
  a_prg_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> banks.prg[1] == 6'd1 && banks.prg[2] == 6'd2 && !rsp_valid)
    else $error("program banks not at reset values");

endmodule

// File: dv/cartridge_bank_mapper_unit_test.sv
// Testbench for cartridge_bank_mapper_unit: directed and random bus accesses,
// with a bank-state predictor checked against every result transfer.
// Depends on cbm_pkg and the cartridge_bank_mapper_unit RTL.
module cartridge_bank_mapper_unit_test;

  localparam logic [1:0]  CMD_RESERVED = 2'd3;
  localparam logic [15:0] HOLE_LO      = 16'h7EF7;
  localparam logic [15:0] HOLE_HI      = 16'h7EF9;
  localparam logic [15:0] PRG_ROM_LO   = 16'h8000;
  localparam int          IDLE_PCT     = 35;
  localparam int          RANDOM_ITEMS = 1600;
  localparam int          REPORT_LIMIT = 10;
  localparam longint      RUN_LIMIT    = 2_000_000;

  logic        clk;
  logic        rst            = 1'b1;
  logic        req_valid      = 1'b0;
  logic        req_stall;
  logic [1:0]  command        = cbm_pkg::CMD_WRITE;
  logic [15:0] bus_address    = '0;
  logic [7:0]  write_data     = '0;
  logic        rsp_valid;
  logic        rsp_stall      = 1'b0;
  logic [2:0]  target;
  logic [18:0] mapped_address;
  logic        mirroring;

  cartridge_bank_mapper_unit dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .command        (command),
    .bus_address    (bus_address),
    .write_data     (write_data),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .target         (target),
    .mapped_address (mapped_address),
    .mirroring      (mirroring)
  );

  // predicted bank state
  logic [1:0] ctrl_bits;
  logic [7:0] chr_bank [6];
  logic [5:0] prg_bank [3];

  cbm_pkg::result_t translations_due [$];
  int      accesses_sent   = 0;
  int      results_checked = 0;
  int      mismatch_count  = 0;
  bit      idling_on       = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout: %0d results still due", translations_due.size());
    $display("** cartridge_bank_mapper_unit: FAILED **");
    $finish;
  end

  function automatic void reset_banks();
    ctrl_bits = '0;
    for (int i = 0; i < 6; i++) chr_bank[i] = '0;
    for (int i = 0; i < 3; i++) prg_bank[i] = 6'(i);
  endfunction

  // Decodes one access against the predicted banks, updating them on
  // register writes; mirroring reflects any update made by this access.
  function automatic cbm_pkg::result_t map_access(input logic [1:0] cmd,
                                                  input logic [15:0] a,
                                                  input logic [7:0] d);
    cbm_pkg::result_t r;
    logic [15:0] off;
    logic [5:0] bank;
    logic [1:0] slot;
    r = '0;
    r.target = cbm_pkg::TGT_NONE;
    case (cmd)
      cbm_pkg::CMD_WRITE: begin
        if (a >= cbm_pkg::CHR_REG_LO && a <= cbm_pkg::CHR_REG_HI) begin
          chr_bank[a[2:0]] = d;
          r.target = cbm_pkg::TGT_REGISTER;
        end else if (a == cbm_pkg::CTRL_REG) begin
          ctrl_bits = d[1:0];
          r.target = cbm_pkg::TGT_REGISTER;
        end else if (a >= cbm_pkg::PRG_REG_LO && a <= cbm_pkg::PRG_REG_HI) begin
          off = a - cbm_pkg::PRG_REG_LO;
          prg_bank[off[1:0]] = d[7:2];
          r.target = cbm_pkg::TGT_REGISTER;
        end else if (a >= HOLE_LO && a <= HOLE_HI) begin
          r.target = cbm_pkg::TGT_NONE;
        end else if (a >= cbm_pkg::WRAM_LO && a <= cbm_pkg::WRAM_HI) begin
          off = a - cbm_pkg::WRAM_LO;
          r.target = cbm_pkg::TGT_WORK;
          r.addr = 19'(off);
        end
      end
      cbm_pkg::CMD_READ: begin
        if (a >= PRG_ROM_LO) begin
          bank = (a[14:13] == cbm_pkg::LAST_WIN) ? cbm_pkg::FIXED_BANK
                                                 : prg_bank[a[14:13]];
          r.target = cbm_pkg::TGT_PROGRAM;
          r.addr = {bank, a[12:0]};
        end else if (a >= cbm_pkg::WRAM_LO) begin
          off = a - cbm_pkg::WRAM_LO;
          r.target = cbm_pkg::TGT_WORK;
          r.addr = 19'(off);
        end
      end
      cbm_pkg::CMD_PPU: begin
        if (a < cbm_pkg::PPU_END) begin
          r.target = cbm_pkg::TGT_CHAR;
          // control bit 1 swaps which half holds the 2K windows
          if ((a[12] ^ ctrl_bits[1]) == 1'b0) begin
            r.addr = 19'({chr_bank[{2'd0, a[11]}][7:1], a[10:0]});
          end else begin
            slot = a[11:10];
            r.addr = 19'({chr_bank[3'(2 + slot)], a[9:0]});
          end
        end
      end
      default: ;
    endcase
    r.mirroring = ctrl_bits[0];
    return r;
  endfunction

  task automatic send_access(input logic [1:0] cmd, input logic [15:0] a, input logic [7:0] d);
    @(negedge clk);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid   <= 1'b1;
    command     <= cmd;
    bus_address <= a;
    write_data  <= d;
    do @(posedge clk); while (req_stall);
    translations_due.push_back(map_access(cmd, a, d));
    accesses_sent++;
  endtask

  task automatic release_bus();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  // receiver stalls
  initial begin
    forever begin
      @(negedge clk);
      rsp_stall <= !rst && idling_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // result checker
  initial begin
    cbm_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        results_checked++;
        if (translations_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d with nothing due: target %0d addr %05h mirr %0b",
                     results_checked, target, mapped_address, mirroring);
        end else begin
          want = translations_due.pop_front();
          if (target !== want.target || mapped_address !== want.addr ||
              mirroring !== want.mirroring) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("result %0d mismatch: expected target %0d addr %05h mirr %0b,",
                       results_checked, want.target, want.addr, want.mirroring);
              $display("  got target %0d addr %05h mirr %0b",
                       target, mapped_address, mirroring);
            end
          end
        end
      end
    end
  end

  // banks straight out of reset: windows 0,1,2 and the fixed last one
  task automatic test_reset_banks();
    send_access(cbm_pkg::CMD_READ, 16'h8000, 8'h00);
    send_access(cbm_pkg::CMD_READ, 16'hA123, 8'h00);
    send_access(cbm_pkg::CMD_READ, 16'hDFFF, 8'h00);
    send_access(cbm_pkg::CMD_READ, 16'hFFFF, 8'h00);
    send_access(cbm_pkg::CMD_PPU,  16'h0000, 8'h00);
    send_access(cbm_pkg::CMD_PPU,  16'h1FFF, 8'h00);
    release_bus();
  endtask

  // register loads, register holes, work memory, out-of-range writes and a reserved command
  task automatic test_write_decode();
    send_access(cbm_pkg::CMD_WRITE, cbm_pkg::CHR_REG_LO, 8'hFF);
    send_access(cbm_pkg::CMD_WRITE, cbm_pkg::CHR_REG_HI, 8'h81);
    send_access(cbm_pkg::CMD_WRITE, cbm_pkg::CTRL_REG,   8'hFF);
    send_access(cbm_pkg::CMD_WRITE, cbm_pkg::PRG_REG_LO, 8'hFF);
    send_access(cbm_pkg::CMD_WRITE, cbm_pkg::PRG_REG_HI, 8'h03);
    send_access(cbm_pkg::CMD_WRITE, HOLE_HI,             8'hFF);
    send_access(cbm_pkg::CMD_WRITE, cbm_pkg::WRAM_LO,    8'h5A);
    send_access(cbm_pkg::CMD_WRITE, cbm_pkg::WRAM_HI,    8'hA5);
    send_access(cbm_pkg::CMD_WRITE, 16'h5FFF,            8'hFF);
    send_access(cbm_pkg::CMD_WRITE, PRG_ROM_LO,          8'hFF);
    send_access(CMD_RESERVED, cbm_pkg::CTRL_REG, 8'h00);
    release_bus();
  endtask

  // read ranges and picture windows in both swap settings
  task automatic test_translation_edges();
    send_access(cbm_pkg::CMD_READ, 16'h0000, 8'h00);
    send_access(cbm_pkg::CMD_READ, 16'h6000, 8'h00);
    send_access(cbm_pkg::CMD_READ, cbm_pkg::CTRL_REG, 8'h00);
    send_access(cbm_pkg::CMD_READ, 16'h9FFF, 8'h00);
    send_access(cbm_pkg::CMD_PPU,  16'h17FF, 8'h00);
    send_access(cbm_pkg::CMD_PPU,  16'h0C00, 8'h00);
    send_access(cbm_pkg::CMD_PPU,  cbm_pkg::PPU_END, 8'h00);
    send_access(cbm_pkg::CMD_WRITE, cbm_pkg::CTRL_REG, 8'h00);
    send_access(cbm_pkg::CMD_PPU,  16'h0FFF, 8'h00);
    send_access(cbm_pkg::CMD_PPU,  16'h1C00, 8'h00);
    release_bus();
  endtask

  // mostly well-formed traffic: bank loads, rom reads and picture fetches,
  // with some work memory and raw noise on every field
  task automatic test_random_traffic();
    int          pick;
    int          reg_idx;
    logic [1:0]  cmd;
    logic [15:0] a;
    logic [7:0]  d;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idling_on = !(n >= 500 && n < 900);
      pick = $urandom_range(99);
      d    = 8'($urandom);
      if (pick < 25) begin
        reg_idx = $urandom_range(9);
        cmd = cbm_pkg::CMD_WRITE;
        a   = (reg_idx < 7) ? cbm_pkg::CHR_REG_LO + 16'(reg_idx)
                            : cbm_pkg::PRG_REG_LO + 16'(reg_idx - 7);
      end else if (pick < 50) begin
        cmd = cbm_pkg::CMD_READ;
        a   = PRG_ROM_LO | 16'($urandom_range(16'h7FFF));
      end else if (pick < 75) begin
        cmd = cbm_pkg::CMD_PPU;
        a   = 16'($urandom_range(16'h1FFF));
      end else if (pick < 87) begin
        cmd = $urandom_range(1) ? cbm_pkg::CMD_READ : cbm_pkg::CMD_WRITE;
        a   = 16'($urandom_range(cbm_pkg::WRAM_HI, cbm_pkg::WRAM_LO));
      end else begin
        cmd = 2'($urandom_range(3));
        a   = 16'($urandom);
      end
      send_access(cmd, a, d);
    end
    idling_on = 1'b1;
    release_bus();
  endtask

  initial begin
    reset_banks();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_banks();
    test_write_decode();
    test_translation_edges();
    test_random_traffic();

    while (translations_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d accesses (writes, rom/work reads, picture fetches, noise),",
             accesses_sent);
    $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && translations_due.size() == 0 && results_checked == accesses_sent)
      $display("** cartridge_bank_mapper_unit: PASSED **");
    else
      $display("** cartridge_bank_mapper_unit: FAILED **");
    $finish;
  end

endmodule

// File: files.f
sv/cbm_pkg.sv
sv/cbm_decode.sv
sv/cartridge_bank_mapper_unit.sv
dv/cartridge_bank_mapper_unit_test.sv
